### rtl/line_pixel_stepper_defines.svh
`ifndef LINE_PIXEL_STEPPER_DEFINES_SVH
`define LINE_PIXEL_STEPPER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define LPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset.
`define LPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/lps_pkg.sv
package lps_pkg;

    localparam int COORD_BITS_DEF  = 10;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_STEP  = 1'b1
    } t_func;

endpackage

### rtl/lps_front.sv
module lps_front
    import lps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int CMD_W      = 1 + 6 * COORD_BITS + 9
) (
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_func,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_ready,
    output logic [CMD_W-1:0]      o_cmd
);

    logic                  dir_x_neg;
    logic                  dir_y_neg;
    logic                  x_is_major;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] dmaj;
    logic [COORD_BITS-1:0] dmin;
    logic [COORD_BITS+1:0] two_dmin;
    logic [COORD_BITS+1:0] two_dmaj;
    logic [COORD_BITS+1:0] err_init;
    logic [COORD_BITS+1:0] inc_minor;

    assign o_cmd_valid = i_in_valid;
    assign o_in_ready  = i_cmd_ready;

    // Line setup; only meaningful for a start beat, a step beat passes func through.
    always_comb begin
        dir_x_neg  = i_end_x < i_start_x;
        dir_y_neg  = i_end_y < i_start_y;
        dx         = dir_x_neg ? (i_start_x - i_end_x) : (i_end_x - i_start_x);
        dy         = dir_y_neg ? (i_start_y - i_end_y) : (i_end_y - i_start_y);
        x_is_major = dx > dy;
        dmaj       = x_is_major ? dx : dy;
        dmin       = x_is_major ? dy : dx;
        two_dmin   = {1'b0, dmin, 1'b0};
        two_dmaj   = {1'b0, dmaj, 1'b0};
        err_init   = two_dmin - {2'b00, dmaj};
        inc_minor  = two_dmin - two_dmaj;
    end

    assign o_cmd = {i_func, i_start_x, i_start_y, dir_x_neg, dir_y_neg, x_is_major,
                    err_init, inc_minor, two_dmin, dmaj};

endmodule

### rtl/lps_queue.sv
module lps_queue
    import lps_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output logic [WIDTH-1:0] o_rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    n_wr_ptr;
    logic [AW-1:0]    n_rd_ptr;
    logic [CW-1:0]    n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_wr_ready = r_count != CW'(DEPTH);
    assign o_rd_valid = r_count != '0;
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CW'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

### rtl/lps_back.sv
module lps_back
    import lps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int CMD_W      = 1 + 6 * COORD_BITS + 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  logic [CMD_W-1:0]      i_cmd,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last,
    output logic                  o_valid_res
);

    localparam int EW = COORD_BITS + 2;

    // unpacked command beat
    logic                  c_func;
    logic [COORD_BITS-1:0] c_x0;
    logic [COORD_BITS-1:0] c_y0;
    logic                  c_dir_x_neg;
    logic                  c_dir_y_neg;
    logic                  c_x_is_major;
    logic [EW-1:0]         c_err;
    logic [EW-1:0]         c_inc_minor;
    logic [EW-1:0]         c_inc_major;
    logic [COORD_BITS-1:0] c_dmaj;

    logic [COORD_BITS-1:0] r_cur_x,  n_cur_x;
    logic [COORD_BITS-1:0] r_cur_y,  n_cur_y;
    logic [EW-1:0]         r_err,    n_err;
    logic [EW-1:0]         r_inc_minor, n_inc_minor;
    logic [EW-1:0]         r_inc_major, n_inc_major;
    logic [COORD_BITS-1:0] r_steps,  n_steps;
    logic                  r_dir_x_neg, n_dir_x_neg;
    logic                  r_dir_y_neg, n_dir_y_neg;
    logic                  r_x_is_major, n_x_is_major;
    logic                  r_active, n_active;

    logic                  r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0] r_pixel_x, n_pixel_x;
    logic [COORD_BITS-1:0] r_pixel_y, n_pixel_y;
    logic                  r_last, n_last;
    logic                  r_valid_res, n_valid_res;

    logic                  pop;
    logic [COORD_BITS-1:0] x_step;
    logic [COORD_BITS-1:0] y_step;

    assign {c_func, c_x0, c_y0, c_dir_x_neg, c_dir_y_neg, c_x_is_major,
            c_err, c_inc_minor, c_inc_major, c_dmaj} = i_cmd;

    // output register frees itself when the downstream takes the beat
    assign o_cmd_ready = !r_out_valid || i_out_ready;
    assign pop         = i_cmd_valid && o_cmd_ready;

    assign x_step = r_dir_x_neg ? (r_cur_x - COORD_BITS'(1)) : (r_cur_x + COORD_BITS'(1));
    assign y_step = r_dir_y_neg ? (r_cur_y - COORD_BITS'(1)) : (r_cur_y + COORD_BITS'(1));

    always_comb begin
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_err        = r_err;
        n_inc_minor  = r_inc_minor;
        n_inc_major  = r_inc_major;
        n_steps      = r_steps;
        n_dir_x_neg  = r_dir_x_neg;
        n_dir_y_neg  = r_dir_y_neg;
        n_x_is_major = r_x_is_major;
        n_active     = r_active;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_pixel_x    = r_pixel_x;
        n_pixel_y    = r_pixel_y;
        n_last       = r_last;
        n_valid_res  = r_valid_res;

        if (pop) begin
            n_out_valid = 1'b1;
            case (t_func'(c_func))
                FUNC_START: begin
                    n_cur_x      = c_x0;
                    n_cur_y      = c_y0;
                    n_err        = c_err;
                    n_inc_minor  = c_inc_minor;
                    n_inc_major  = c_inc_major;
                    n_steps      = c_dmaj;
                    n_dir_x_neg  = c_dir_x_neg;
                    n_dir_y_neg  = c_dir_y_neg;
                    n_x_is_major = c_x_is_major;
                    n_active     = c_dmaj != '0;
                    n_pixel_x    = c_x0;
                    n_pixel_y    = c_y0;
                    n_last       = c_dmaj == '0;
                    n_valid_res  = 1'b1;
                end
                FUNC_STEP: begin
                    if (!r_active) begin
                        n_pixel_x   = '0;
                        n_pixel_y   = '0;
                        n_last      = 1'b0;
                        n_valid_res = 1'b0;
                    end else begin
                        // error sign picks whether the minor axis moves
                        if (!r_err[EW-1]) begin
                            n_err = r_err + r_inc_minor;
                            n_cur_x = x_step;
                            n_cur_y = y_step;
                        end else begin
                            n_err = r_err + r_inc_major;
                            n_cur_x = r_x_is_major ? x_step : r_cur_x;
                            n_cur_y = r_x_is_major ? r_cur_y : y_step;
                        end
                        n_steps     = r_steps - COORD_BITS'(1);
                        n_active    = n_steps != '0;
                        n_pixel_x   = n_cur_x;
                        n_pixel_y   = n_cur_y;
                        n_last      = n_steps == '0;
                        n_valid_res = 1'b1;
                    end
                end
                default: begin
                    n_out_valid = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_err        <= '0;
            r_inc_minor  <= '0;
            r_inc_major  <= '0;
            r_steps      <= '0;
            r_dir_x_neg  <= 1'b0;
            r_dir_y_neg  <= 1'b0;
            r_x_is_major <= 1'b0;
            r_active     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_cur_x      <= n_cur_x;
            r_cur_y      <= n_cur_y;
            r_err        <= n_err;
            r_inc_minor  <= n_inc_minor;
            r_inc_major  <= n_inc_major;
            r_steps      <= n_steps;
            r_dir_x_neg  <= n_dir_x_neg;
            r_dir_y_neg  <= n_dir_y_neg;
            r_x_is_major <= n_x_is_major;
            r_active     <= n_active;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pixel_x   <= n_pixel_x;
        r_pixel_y   <= n_pixel_y;
        r_last      <= n_last;
        r_valid_res <= n_valid_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_x   = r_pixel_x;
    assign o_pixel_y   = r_pixel_y;
    assign o_last      = r_last;
    assign o_valid_res = r_valid_res;

endmodule

### rtl/line_pixel_stepper.sv
// Path: a beat accepted at the input is written into the command queue, then into the
// stepper's output register, before its pixel shows at the output.
// Throughput: one beat per cycle, start or step, while the output is not stalled; each
// step is one error compare and two coordinate adds on the stepper's registers.
// Reset (i_rst_n low, synchronous): queue empty, no line in progress, output idle.
module line_pixel_stepper
    import lps_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_func,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last,
    output logic                  o_valid_res
);

    localparam int CMD_W = 1 + 6 * COORD_BITS + 9;

    logic             fe_valid;
    logic             fe_ready;
    logic [CMD_W-1:0] fe_cmd;
    logic             be_valid;
    logic             be_ready;
    logic [CMD_W-1:0] be_cmd;

    lps_front #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .o_cmd_valid (fe_valid),
        .i_cmd_ready (fe_ready),
        .o_cmd       (fe_cmd)
    );

    lps_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fe_valid),
        .o_wr_ready (fe_ready),
        .i_wr_data  (fe_cmd),
        .o_rd_valid (be_valid),
        .i_rd_ready (be_ready),
        .o_rd_data  (be_cmd)
    );

    lps_back #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (be_valid),
        .o_cmd_ready (be_ready),
        .i_cmd       (be_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_last      (o_last),
        .o_valid_res (o_valid_res)
    );

endmodule

### rtl/lps_checker.sv
`include "line_pixel_stepper_defines.svh"

module lps_checker
    import lps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  i_func,
    input logic [COORD_BITS-1:0] i_start_x,
    input logic [COORD_BITS-1:0] i_start_y,
    input logic [COORD_BITS-1:0] i_end_x,
    input logic [COORD_BITS-1:0] i_end_y,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [COORD_BITS-1:0] o_pixel_x,
    input logic [COORD_BITS-1:0] o_pixel_y,
    input logic                  o_last,
    input logic                  o_valid_res
);

    logic [4*COORD_BITS:0]   in_beat;
    logic [2*COORD_BITS+1:0] out_beat;

    assign in_beat  = {i_func, i_start_x, i_start_y, i_end_x, i_end_y};
    assign out_beat = {o_pixel_x, o_pixel_y, o_last, o_valid_res};

    // a stalled input beat keeps its payload
    `LPS_ASSERT_NEXT(a_in_hold, i_in_valid && !o_in_ready, i_in_valid && $stable(in_beat), "input beat changed while stalled")

    // a stalled result beat keeps its pixel
    `LPS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(out_beat), "result beat changed while stalled")

    // a step with no line reports an all-zero pixel
    `LPS_ASSERT_NOW(a_idle_zero, o_out_valid && !o_valid_res, o_pixel_x == '0 && o_pixel_y == '0 && !o_last, "idle step result not zero")

    // only a real pixel can close a line
    `LPS_ASSERT_NOW(a_last_valid, o_out_valid && o_last, o_valid_res, "last flagged on idle step")

endmodule

bind line_pixel_stepper lps_checker #(.COORD_BITS(COORD_BITS)) u_lps_checker (.*);

### tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lps_pkg::*;

    localparam int CB          = COORD_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          last;
        logic          vres;
    } t_pixel;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    logic          func = FUNC_START;
    logic [CB-1:0] start_x = '0;
    logic [CB-1:0] start_y = '0;
    logic [CB-1:0] end_x = '0;
    logic [CB-1:0] end_y = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [CB-1:0] pixel_x;
    logic [CB-1:0] pixel_y;
    logic          pixel_last;
    logic          pixel_vres;

    line_pixel_stepper dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_func      (func),
        .i_start_x   (start_x),
        .i_start_y   (start_y),
        .i_end_x     (end_x),
        .i_end_y     (end_y),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_pixel_x   (pixel_x),
        .o_pixel_y   (pixel_y),
        .o_last      (pixel_last),
        .o_valid_res (pixel_vres)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // line tracer state
    logic [CB-1:0]        ln_x = '0;
    logic [CB-1:0]        ln_y = '0;
    logic signed [CB+1:0] ln_err = '0;
    logic signed [CB+1:0] ln_inc_diag = '0;
    logic signed [CB+1:0] ln_inc_axis = '0;
    logic [CB-1:0]        ln_left = '0;
    logic                 ln_xneg = 1'b0;
    logic                 ln_yneg = 1'b0;
    logic                 ln_xmajor = 1'b0;
    logic                 ln_busy = 1'b0;

    t_pixel pixel_q[$];
    t_pixel got_px;
    t_pixel want_px;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int send_calm = 0;
    int recv_calm = 0;
    int beats_sent = 0;
    int mismatches = 0;
    int cycles = 0;

    function automatic logic [CB-1:0] nudge(logic [CB-1:0] v, logic neg);
        return neg ? v - 1'b1 : v + 1'b1;
    endfunction

    function automatic logic [CB-1:0] rand_coord();
        return CB'($urandom_range(0, (1 << CB) - 1));
    endfunction

    function automatic t_pixel trace_pixel(t_func f, logic [CB-1:0] sx, logic [CB-1:0] sy,
                                           logic [CB-1:0] ex, logic [CB-1:0] ey);
        int dx;
        int dy;
        int dmaj;
        int dmin;
        t_pixel px;
        if (f == FUNC_START) begin
            ln_xneg = ex < sx;
            ln_yneg = ey < sy;
            dx = ln_xneg ? int'(sx) - int'(ex) : int'(ex) - int'(sx);
            dy = ln_yneg ? int'(sy) - int'(ey) : int'(ey) - int'(sy);
            ln_xmajor = dx > dy;
            dmaj = ln_xmajor ? dx : dy;
            dmin = ln_xmajor ? dy : dx;
            ln_err = (CB+2)'(2 * dmin - dmaj);
            ln_inc_diag = (CB+2)'(2 * (dmin - dmaj));
            ln_inc_axis = (CB+2)'(2 * dmin);
            ln_left = CB'(dmaj);
            ln_x = sx;
            ln_y = sy;
            ln_busy = ln_left != 0;
            px = '{ln_x, ln_y, !ln_busy, 1'b1};
        end else if (!ln_busy) begin
            px = '0;
        end else begin
            if (ln_err >= 0) begin
                if (ln_xmajor)
                    ln_y = nudge(ln_y, ln_yneg);
                else
                    ln_x = nudge(ln_x, ln_xneg);
                ln_err = ln_err + ln_inc_diag;
            end else begin
                ln_err = ln_err + ln_inc_axis;
            end
            if (ln_xmajor)
                ln_x = nudge(ln_x, ln_xneg);
            else
                ln_y = nudge(ln_y, ln_yneg);
            ln_left = ln_left - 1'b1;
            ln_busy = ln_left != 0;
            px = '{ln_x, ln_y, !ln_busy, 1'b1};
        end
        return px;
    endfunction

    // Drive one beat at the falling edge; valid stays up from the previous beat
    // unless an idle cycle is drawn.
    task automatic send_beat(t_func f, logic [CB-1:0] sx, logic [CB-1:0] sy,
                             logic [CB-1:0] ex, logic [CB-1:0] ey);
        @(negedge i_clk);
        if (send_calm > 0) begin
            send_calm--;
        end else begin
            if ($urandom_range(0, 59) == 0)
                send_calm = $urandom_range(8, 30);
            while ($urandom_range(0, 99) < send_idle_pct) begin
                in_valid = 1'b0;
                @(negedge i_clk);
            end
        end
        in_valid = 1'b1;
        func     = f;
        start_x  = sx;
        start_y  = sy;
        end_x    = ex;
        end_y    = ey;
        do @(posedge i_clk); while (!in_ready);
        pixel_q.push_back(trace_pixel(f, sx, sy, ex, ey));
        beats_sent++;
    endtask

    task automatic send_step();
        send_beat(FUNC_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic send_steps(int n);
        repeat (n) send_step();
    endtask

    always @(negedge i_clk) begin
        if (recv_calm > 0) begin
            recv_calm--;
            out_ready = 1'b1;
        end else begin
            if ($urandom_range(0, 199) == 0)
                recv_calm = $urandom_range(10, 40);
            out_ready = $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            got_px = '{pixel_x, pixel_y, pixel_last, pixel_vres};
            if (pixel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel beat: x=%0d y=%0d last=%0b valid_res=%0b",
                             got_px.x, got_px.y, got_px.last, got_px.vres);
            end else begin
                want_px = pixel_q.pop_front();
                if (got_px.x !== want_px.x || got_px.y !== want_px.y ||
                    got_px.last !== want_px.last || got_px.vres !== want_px.vres) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"pixel mismatch: expected x=%0d y=%0d last=%0b ",
                                  "valid_res=%0b, got x=%0d y=%0d last=%0b valid_res=%0b"},
                                 want_px.x, want_px.y, want_px.last, want_px.vres,
                                 got_px.x, got_px.y, got_px.last, got_px.vres);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic test_steps_without_line();
        send_steps(2);
    endtask

    task automatic test_directed_lines();
        // single point: last on the start pixel, nothing left to step
        send_beat(FUNC_START, 10'd5, 10'd5, 10'd5, 10'd5);
        send_step();
        // corner-to-corner diagonals, each abandoned by the next start
        send_beat(FUNC_START, 10'd0, 10'd0, 10'd1023, 10'd1023);
        send_steps(2);
        send_beat(FUNC_START, 10'd1023, 10'd1023, 10'd0, 10'd0);
        send_step();
        send_beat(FUNC_START, 10'd0, 10'd1023, 10'd1023, 10'd0);
        send_step();
        send_beat(FUNC_START, 10'd1023, 10'd0, 10'd0, 10'd1023);
        send_step();
        // x-major, run past the end
        send_beat(FUNC_START, 10'd10, 10'd10, 10'd13, 10'd11);
        send_steps(4);
        // y-major going down in both axes
        send_beat(FUNC_START, 10'd20, 10'd20, 10'd19, 10'd16);
        send_steps(4);
        // x-major going left
        send_beat(FUNC_START, 10'd3, 10'd0, 10'd0, 10'd1);
        send_steps(3);
    endtask

    task automatic test_random_lines(int n_beats);
        int stop_at;
        int mode;
        int len;
        int n_steps;
        logic [CB-1:0] sx;
        logic [CB-1:0] sy;
        logic [CB-1:0] ex;
        logic [CB-1:0] ey;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at) begin
            mode = $urandom_range(0, 99);
            if (mode < 75) begin
                sx = rand_coord();
                sy = rand_coord();
                if ($urandom_range(0, 3) == 0) begin
                    sx = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
                    sy = $urandom_range(0, 1) ? 10'd1022 : 10'd1;
                end
                ex = CB'($urandom_range(sx > 12 ? sx - 12 : 0, sx < 1011 ? sx + 12 : 1023));
                ey = CB'($urandom_range(sy > 12 ? sy - 12 : 0, sy < 1011 ? sy + 12 : 1023));
                len = (ex > sx) ? ex - sx : sx - ex;
                if (((ey > sy) ? ey - sy : sy - ey) > len)
                    len = (ey > sy) ? ey - sy : sy - ey;
                n_steps = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len)
                                                      : len + $urandom_range(0, 2);
                send_beat(FUNC_START, sx, sy, ex, ey);
                send_steps(n_steps);
            end else if (mode < 90) begin
                send_beat(FUNC_START, rand_coord(), rand_coord(), rand_coord(), rand_coord());
                send_steps($urandom_range(0, 15));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_beat(t_func'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord());
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct  = 26;
        recv_stall_pct = 67;
        test_steps_without_line();
        test_directed_lines();
        test_random_lines(210);

        send_idle_pct  = 67;
        recv_stall_pct = 26;
        test_random_lines(240);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_lines(240);

        @(negedge i_clk);
        in_valid = 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
